// File: hdl/nsa_pkg.sv
// Shared types and constants for the 1D spread-and-accumulate gridding block.
// Used by nsa_ctrl, nsa_datapath and nufft_spread_accumulate_1d; depends on nothing.
`default_nettype none

package nsa_pkg;

    localparam int GRID_DEPTH = 4096;
    localparam int MAX_SPREAD = 16;

    localparam int ADDR_W   = $clog2(GRID_DEPTH);
    localparam int RW       = $clog2(MAX_SPREAD + 1);
    localparam int SIZE_W   = 13;
    localparam int SPREAD_W = 5;
    localparam int POS_W    = 16;
    localparam int VAL_W    = 32;
    localparam int SUM_W    = 48;
    localparam int CMP_W    = ((POS_W > ADDR_W) ? POS_W : ADDR_W) + 2;
    localparam int CFG_W    = SIZE_W;
    localparam int CFG_IDX_W = 1;

    localparam int GRID_SIZE_RST = 4096;
    localparam int SPREAD_RST    = 4;
    localparam int RST_LAST  = ((GRID_SIZE_RST > GRID_DEPTH) ? GRID_DEPTH : GRID_SIZE_RST) - 1;
    localparam int RST_WIDTH = (SPREAD_RST > MAX_SPREAD) ? MAX_SPREAD : SPREAD_RST;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_WIDTH = 1'b1;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic MODE_SPREAD = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_SP_HEAD  = 8'b0000_0100,
        S_SP_BODY  = 8'b0000_1000,
        S_SP_TAIL  = 8'b0001_0000,
        S_RD_ISSUE = 8'b0010_0000,
        S_RD_DONE  = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } t_nsa_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic rd_issue;
        logic wr_acc;
        logic wr_zero;
        logic push;
    } t_nsa_cmd;

    typedef struct packed {
        logic in_err;
        logic in_mode;
        logic k_at_hi;
        logic clr_done;
        logic out_free;
    } t_nsa_sts;

endpackage

`default_nettype wire

// File: hdl/nsa_ctrl.sv
// Controller state machine for the spread-and-accumulate block.
// Depends on nsa_pkg; drives command signals into nsa_datapath.
`default_nettype none

module nsa_ctrl import nsa_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    output logic          o_s_tready,
    input  wire t_nsa_sts i_sts,
    output t_nsa_cmd      o_cmd
);

    t_nsa_state r_state;
    t_nsa_state n_state;
    logic       w_accept;

    assign w_accept = (r_state == S_IDLE) && i_s_tvalid;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_err) begin
                        n_state = S_FINISH;
                    end else if (i_sts.in_mode == MODE_READ) begin
                        n_state = S_RD_ISSUE;
                    end else begin
                        n_state = S_SP_HEAD;
                    end
                end
            end
            S_SP_HEAD: begin
                o_cmd.rd_issue = 1'b1;
                n_state = i_sts.k_at_hi ? S_SP_TAIL : S_SP_BODY;
            end
            S_SP_BODY: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.wr_acc   = 1'b1;
                n_state = i_sts.k_at_hi ? S_SP_TAIL : S_SP_BODY;
            end
            S_SP_TAIL: begin
                o_cmd.wr_acc = 1'b1;
                n_state = S_FINISH;
            end
            S_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_RD_DONE;
            end
            S_RD_DONE: begin
                o_cmd.wr_zero = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: hdl/nsa_datapath.sv
// Datapath: configuration registers, grid accumulator memory, saturating adder
// and output register. Depends on nsa_pkg; commanded by nsa_ctrl.
`default_nettype none

module nsa_datapath import nsa_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_nsa_cmd              i_cmd,
    output t_nsa_sts                   o_sts,
    input  wire logic [47:0]           i_s_tdata,
    input  wire logic [0:0]            i_s_tuser,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_wdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [SUM_W-1:0]           o_m_tdata,
    output logic [0:0]                 o_m_tuser
);

    logic [ADDR_W-1:0] r_last_cell;
    logic [RW-1:0]     r_width_m1;
    logic [RW-1:0]     r_half;

    logic [SIZE_W-1:0]   w_gs;
    logic [SPREAD_W-1:0] w_sw;
    logic [RW-1:0]       w_r;

    logic [SUM_W-1:0]  r_mem [GRID_DEPTH];
    logic [SUM_W-1:0]  r_rd_data;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_k;
    logic [ADDR_W-1:0] r_hi;
    logic [ADDR_W-1:0] r_wr_addr;
    logic signed [VAL_W-1:0] r_val;
    logic              r_err;
    logic [SUM_W-1:0]  r_sum;

    logic              r_out_valid;
    logic [SUM_W-1:0]  r_out_sum;
    logic              r_out_err;

    logic signed [POS_W-1:0] w_pos;
    logic signed [CMP_W-1:0] w_pos_x;
    logic signed [CMP_W-1:0] w_last_x;
    logic signed [CMP_W-1:0] w_start_x;
    logic signed [CMP_W-1:0] w_end_x;
    logic                    w_in_err;
    logic [ADDR_W-1:0]       w_lo;
    logic [ADDR_W-1:0]       w_hi;

    logic signed [SUM_W:0] w_acc;
    logic [SUM_W-1:0]      w_sat;
    logic                  w_mem_we;
    logic [ADDR_W-1:0]     w_mem_waddr;
    logic [SUM_W-1:0]      w_mem_wdata;

    // Configuration values are stored already clamped to their legal ranges.
    assign w_gs = i_cfg_wdata[SIZE_W-1:0];
    assign w_sw = i_cfg_wdata[SPREAD_W-1:0];

    always_comb begin
        if (w_sw == '0) begin
            w_r = RW'(1);
        end else if (32'(w_sw) > MAX_SPREAD) begin
            w_r = RW'(MAX_SPREAD);
        end else begin
            w_r = RW'(w_sw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cell <= ADDR_W'(RST_LAST);
            r_width_m1  <= RW'(RST_WIDTH - 1);
            r_half      <= RW'(RST_WIDTH / 2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_SIZE: begin
                    if (w_gs == '0) begin
                        r_last_cell <= '0;
                    end else if (32'(w_gs) > GRID_DEPTH) begin
                        r_last_cell <= ADDR_W'(GRID_DEPTH - 1);
                    end else begin
                        r_last_cell <= ADDR_W'(w_gs - SIZE_W'(1));
                    end
                end
                CFG_SPREAD_WIDTH: begin
                    r_width_m1 <= w_r - RW'(1);
                    r_half     <= w_r >> 1;
                end
                default: begin
                end
            endcase
        end
    end

    // Footprint of a point, clipped to the grid at load time.
    assign w_pos     = $signed(i_s_tdata[POS_W-1:0]);
    assign w_pos_x   = CMP_W'(w_pos);
    assign w_last_x  = $signed(CMP_W'(r_last_cell));
    assign w_in_err  = (w_pos_x < 0) || (w_pos_x > w_last_x);
    assign w_start_x = w_pos_x - $signed(CMP_W'(r_half));
    assign w_end_x   = w_start_x + $signed(CMP_W'(r_width_m1));
    assign w_lo      = (w_start_x < 0) ? '0 : w_start_x[ADDR_W-1:0];
    assign w_hi      = (w_end_x > w_last_x) ? r_last_cell : w_end_x[ADDR_W-1:0];

    assign w_acc = $signed({r_rd_data[SUM_W-1], r_rd_data}) + (SUM_W+1)'(r_val);

    always_comb begin
        if (w_acc[SUM_W] != w_acc[SUM_W-1]) begin
            w_sat = w_acc[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            w_sat = w_acc[SUM_W-1:0];
        end
    end

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_wr_addr;
        w_mem_wdata = '0;
        priority if (i_cmd.clr_step) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_addr;
        end else if (i_cmd.wr_acc) begin
            w_mem_we    = 1'b1;
            w_mem_wdata = w_sat;
        end else if (i_cmd.wr_zero) begin
            w_mem_we    = 1'b1;
        end else begin
            w_mem_we    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= $signed(i_s_tdata[POS_W +: VAL_W]);
            r_err <= w_in_err;
            r_sum <= '0;
            if (i_s_tuser[0] == MODE_READ) begin
                r_k  <= w_pos_x[ADDR_W-1:0];
                r_hi <= w_pos_x[ADDR_W-1:0];
            end else begin
                r_k  <= w_lo;
                r_hi <= w_hi;
            end
        end else begin
            if (i_cmd.rd_issue) begin
                r_k       <= r_k + ADDR_W'(1);
                r_wr_addr <= r_k;
            end
            if (i_cmd.wr_zero) begin
                r_sum <= r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_sum <= r_sum;
            r_out_err <= r_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_sum;
    assign o_m_tuser  = r_out_err;

    assign o_sts.in_err   = w_in_err;
    assign o_sts.in_mode  = i_s_tuser[0];
    assign o_sts.k_at_hi  = (r_k == r_hi);
    assign o_sts.clr_done = (r_clr_addr == ADDR_W'(GRID_DEPTH - 1));
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (!r_out_valid || i_m_tready))
        else $error("Result pushed over an untaken result.");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (r_k <= r_hi))
        else $error("Cell read past the end of the footprint.");

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_acc |-> $past(i_cmd.rd_issue))
        else $error("Accumulate write without a preceding read.");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_sum == '0))
        else $error("Flagged result carries a nonzero sum.");

endmodule

`default_nettype wire

// File: hdl/nufft_spread_accumulate_1d.sv
// A spread item reads each cell of its footprint in turn and writes back the saturated
// sum, a read item reads its one cell and writes zero to it, an out-of-grid item is flagged.
// A new item is taken only after the result of the last one has gone to the output
// register; spreads run at one read-modify-write per cycle on the grid memory.
// Reset is synchronous and active low; afterwards a clearing pass writes zero to all
// 4096 grid cells, during which no item is taken.
`default_nettype none

module nufft_spread_accumulate_1d import nsa_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [47:0]          i_s_tdata,   // position[15:0], sample_value[47:16]
    input  wire logic [0:0]           i_s_tuser,   // mode[0]
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [SUM_W-1:0]          o_m_tdata,   // cell_sum[47:0]
    output logic [0:0]                o_m_tuser,   // point_error[0]
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    t_nsa_cmd w_cmd;
    t_nsa_sts w_sts;

    nsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    nsa_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire
